// ===== hw/rtl/ddmrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ddmrc_pkg;

    localparam int SPEED_W         = 12;
    localparam int SPEED_FRAC_BITS = 4;
    localparam int STEP_W          = 8;
    localparam int DIV_W           = 8;
    localparam int OUT_SPEED_W     = 8;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 12;

    localparam logic [SPEED_W-1:0] RST_MAX_FREQ    = 12'd1920;
    localparam logic [SPEED_W-1:0] RST_MIN_FREQ    = 12'd160;
    localparam logic [STEP_W-1:0]  RST_RAMP_STEP   = 8'd38;
    localparam logic [DIV_W-1:0]   RST_RAMP_DIVIDE = 8'd10;
    localparam logic [SPEED_W-1:0] RST_SPEED       = 12'd160;

    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        ST_CLOSING = 2'd0,
        ST_CLOSED  = 2'd1,
        ST_OPENING = 2'd2,
        ST_OPENED  = 2'd3
    } door_st_t;

    localparam logic [1:0] CMD_CLOSE = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_FREQ    = 2'd0,
        CFG_MIN_FREQ    = 2'd1,
        CFG_RAMP_STEP   = 2'd2,
        CFG_RAMP_DIVIDE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SPEED_W-1:0] max_freq;
        logic [SPEED_W-1:0] min_freq;
        logic [STEP_W-1:0]  ramp_step;
    } ramp_cfg_t;

    typedef struct packed {
        door_st_t           state;
        logic [SPEED_W-1:0] ramp_speed;
        logic [SPEED_W-1:0] sent_speed;
        dir_t               sent_dir;
    } door_ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ddmrc_door.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddmrc_door (
    input  ddmrc_pkg::door_ctx_t ctx,
    input  ddmrc_pkg::ramp_cfg_t cfg,
    input  logic [1:0]           cmd,
    input  logic                 lim_closed,
    input  logic                 lim_opened,
    input  logic                 ramp_tick,
    output ddmrc_pkg::door_ctx_t ctx_next,
    output logic                 update
);
    import ddmrc_pkg::*;

    door_st_t           st;
    dir_t               dir;
    logic [SPEED_W:0]   sum;
    logic [SPEED_W-1:0] speed;

    // end switches latch first, opened wins
    always_comb
    begin
        st = ctx.state;
        if (lim_closed)
            st = ST_CLOSED;
        if (lim_opened)
            st = ST_OPENED;
        dir = DIR_STOP;
        if (cmd == CMD_CLOSE && st != ST_CLOSED)
        begin
            st  = ST_CLOSING;
            dir = DIR_FWD;
        end
        else if (cmd == CMD_OPEN && st != ST_OPENED)
        begin
            st  = ST_OPENING;
            dir = DIR_REV;
        end
    end

    always_comb
    begin
        sum   = {1'b0, ctx.ramp_speed} + {{(SPEED_W + 1 - STEP_W){1'b0}}, cfg.ramp_step};
        speed = ctx.ramp_speed;
        if (ramp_tick)
        begin
            if (dir == DIR_STOP)
                speed = cfg.min_freq;
            else if (sum < {1'b0, cfg.max_freq})
                speed = sum[SPEED_W-1:0];
            else
                speed = cfg.max_freq;
            if (ctx.sent_dir != dir)
                speed = cfg.min_freq;
        end
    end

    always_comb
    begin
        update              = (ctx.sent_speed != speed) || (ctx.sent_dir != dir);
        ctx_next.state      = st;
        ctx_next.ramp_speed = speed;
        ctx_next.sent_speed = speed;
        ctx_next.sent_dir   = dir;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_door_motor_ramp_controller_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-door motor ramp controller. Each request is one control tick with both
// door commands and the four end switches; it returns one result with the
// door states, the last sent motor direction and speed (whole hertz) and an
// update flag per motor. One request is taken every clock cycle while the
// result is not stalled; a request passes through the input register, then
// the result register, with door and ramp state updated as it moves into
// the result register. A stalled result holds the input register, which
// then stalls the input.
// Configuration writes are taken any time, but belong between requests
// while the block is idle.

module dual_door_motor_ramp_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ddmrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ddmrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          door_cmd_a,
    input  logic [1:0]                          door_cmd_b,
    input  logic                                limit_closed_a,
    input  logic                                limit_opened_a,
    input  logic                                limit_closed_b,
    input  logic                                limit_opened_b,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                update_a,
    output logic [1:0]                          dir_a,
    output logic [ddmrc_pkg::OUT_SPEED_W-1:0]   speed_a,
    output logic                                update_b,
    output logic [1:0]                          dir_b,
    output logic [ddmrc_pkg::OUT_SPEED_W-1:0]   speed_b,
    output logic [1:0]                          state_a,
    output logic [1:0]                          state_b
);
    import ddmrc_pkg::*;

    ramp_cfg_t          cfg_reg;
    logic [DIV_W-1:0]   ramp_divide_reg;

    logic               s1_valid_reg;
    logic [1:0]         cmd_a_reg, cmd_b_reg;
    logic               lc_a_reg, lo_a_reg, lc_b_reg, lo_b_reg;

    door_ctx_t          ctx_a_reg, ctx_b_reg;
    door_ctx_t          ctx_a_next, ctx_b_next;
    logic [DIV_W-1:0]   prescale_reg, prescale_next;
    logic [DIV_W-1:0]   prescale_inc;
    logic               ramp_tick;
    logic               upd_a, upd_b;

    logic               out_valid_reg;
    logic               out_free, s1_advance, in_take;
    logic [SPEED_W-1:0] shift_a, shift_b;

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_freq  <= RST_MAX_FREQ;
            cfg_reg.min_freq  <= RST_MIN_FREQ;
            cfg_reg.ramp_step <= RST_RAMP_STEP;
            ramp_divide_reg   <= RST_RAMP_DIVIDE;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MAX_FREQ:    cfg_reg.max_freq  <= cfg_data[SPEED_W-1:0];
                CFG_MIN_FREQ:    cfg_reg.min_freq  <= cfg_data[SPEED_W-1:0];
                CFG_RAMP_STEP:   cfg_reg.ramp_step <= cfg_data[STEP_W-1:0];
                CFG_RAMP_DIVIDE: ramp_divide_reg   <= cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_a_reg <= door_cmd_a;
            cmd_b_reg <= door_cmd_b;
            lc_a_reg  <= limit_closed_a;
            lo_a_reg  <= limit_opened_a;
            lc_b_reg  <= limit_closed_b;
            lo_b_reg  <= limit_opened_b;
        end
    end

    // shared ramp prescaler
    always_comb
    begin
        prescale_inc  = prescale_reg + 1'b1;
        ramp_tick     = prescale_inc >= ramp_divide_reg;
        prescale_next = ramp_tick ? '0 : prescale_inc;
    end

    ddmrc_door u_door_a (
        .ctx        (ctx_a_reg),
        .cfg        (cfg_reg),
        .cmd        (cmd_a_reg),
        .lim_closed (lc_a_reg),
        .lim_opened (lo_a_reg),
        .ramp_tick  (ramp_tick),
        .ctx_next   (ctx_a_next),
        .update     (upd_a)
    );

    ddmrc_door u_door_b (
        .ctx        (ctx_b_reg),
        .cfg        (cfg_reg),
        .cmd        (cmd_b_reg),
        .lim_closed (lc_b_reg),
        .lim_opened (lo_b_reg),
        .ramp_tick  (ramp_tick),
        .ctx_next   (ctx_b_next),
        .update     (upd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_a_reg     <= '{state: ST_CLOSING, ramp_speed: RST_SPEED,
                               sent_speed: RST_SPEED, sent_dir: DIR_STOP};
            ctx_b_reg     <= '{state: ST_CLOSING, ramp_speed: RST_SPEED,
                               sent_speed: RST_SPEED, sent_dir: DIR_STOP};
            prescale_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_advance)
            begin
                ctx_a_reg    <= ctx_a_next;
                ctx_b_reg    <= ctx_b_next;
                prescale_reg <= prescale_next;
            end
            if (s1_advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign shift_a = ctx_a_next.sent_speed >> SPEED_FRAC_BITS;
    assign shift_b = ctx_b_next.sent_speed >> SPEED_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            update_a <= upd_a;
            dir_a    <= ctx_a_next.sent_dir;
            speed_a  <= shift_a[OUT_SPEED_W-1:0];
            update_b <= upd_b;
            dir_b    <= ctx_b_next.sent_dir;
            speed_b  <= shift_b[OUT_SPEED_W-1:0];
            state_a  <= ctx_a_next.state;
            state_b  <= ctx_b_next.state;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ddmrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ddmrc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic                                update_a,
    input  logic [1:0]                          dir_a,
    input  logic [ddmrc_pkg::OUT_SPEED_W-1:0]   speed_a,
    input  logic [1:0]                          dir_b,
    input  logic [1:0]                          state_a,
    input  logic [1:0]                          state_b
);
    import ddmrc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dir_a) && $stable(speed_a)
            && $stable(update_a))
        else $error("result changed while stalled");

    // a door at its closed end never drives forward, at its opened end never reverse
    a_dir_vs_state_a: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(state_a == ST_CLOSED && dir_a == DIR_FWD)
            && !(state_a == ST_OPENED && dir_a == DIR_REV))
        else $error("door A direction against its end state");

    a_dir_vs_state_b: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(state_b == ST_CLOSED && dir_b == DIR_FWD)
            && !(state_b == ST_OPENED && dir_b == DIR_REV))
        else $error("door B direction against its end state");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dir_a != 2'd3 && dir_b != 2'd3)
        else $error("invalid direction code");

endmodule

bind dual_door_motor_ramp_controller_core ddmrc_checker u_ddmrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .update_a  (update_a),
    .dir_a     (dir_a),
    .speed_a   (speed_a),
    .dir_b     (dir_b),
    .state_a   (state_a),
    .state_b   (state_b)
);

`default_nettype wire
